// ----- sv/tcc_pkg.sv -----
// ----------------------------------------------------------------------------
// tcc_pkg: shared constants for the tetrahedron circumcentre pipeline
// Default coordinate width, multiplier slice width and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int MUL_CHUNK       = 32;
  localparam int STATUS_W        = 2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DEGEN = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SAT   = 2'd2;

endpackage

`default_nettype wire

// ----- sv/tcc_dly.sv -----
// ----------------------------------------------------------------------------
// tcc_dly: enabled delay line
// Carries side data alongside the arithmetic stages, N registers deep.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int i = 1; i < N; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign q = sr[N-1];

endmodule

`default_nettype wire

// ----- sv/tcc_mul.sv -----
// ----------------------------------------------------------------------------
// tcc_mul: pipelined signed multiplier
// Slices both operands, forms slice products, then row sums, then the total.
// Three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_mul import tcc_pkg::*; #(
  parameter int AW = 33,
  parameter int BW = 33,
  parameter int CH = MUL_CHUNK
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);

  localparam int NA  = (AW + CH - 1) / CH;
  localparam int NB  = (BW + CH - 1) / CH;
  localparam int RW  = AW + BW;
  localparam int AXW = NA * CH;
  localparam int BXW = NB * CH;

  logic signed [AXW-1:0]  ax;
  logic signed [BXW-1:0]  bx;
  logic signed [CH:0]     ac [NA];
  logic signed [CH:0]     bc [NB];
  logic signed [2*CH+1:0] pp [NA][NB];
  logic signed [RW-1:0]   rsum [NA];
  logic signed [RW-1:0]   rows [NA];
  logic signed [RW-1:0]   total;

  assign ax = AXW'(a);
  assign bx = BXW'(b);

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      if (i == NA - 1) begin
        ac[i] = $signed({ax[i*CH+CH-1], ax[i*CH +: CH]});
      end else begin
        ac[i] = $signed({1'b0, ax[i*CH +: CH]});
      end
    end
    for (int j = 0; j < NB; j++) begin
      if (j == NB - 1) begin
        bc[j] = $signed({bx[j*CH+CH-1], bx[j*CH +: CH]});
      end else begin
        bc[j] = $signed({1'b0, bx[j*CH +: CH]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= ac[i] * bc[j];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      rsum[i] = '0;
      for (int j = 0; j < NB; j++) begin
        rsum[i] = rsum[i] + (RW'(pp[i][j]) <<< (j * CH));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rows <= rsum;
    end
  end

  always_comb begin
    total = '0;
    for (int i = 0; i < NA; i++) begin
      total = total + (rows[i] <<< (i * CH));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= total;
    end
  end

endmodule

`default_nettype wire

// ----- sv/tcc_div.sv -----
// ----------------------------------------------------------------------------
// tcc_div: pipelined restoring divider
// One range check stage, then one quotient bit per stage, most significant
// first. Flags a quotient that does not fit in QW bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_div #(
  parameter int NUMW = 138,
  parameter int DENW = 104,
  parameter int QW   = 34
) (
  input  logic            clk,
  input  logic            en,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  output logic [QW-1:0]   quo,
  output logic            ovf
);

  localparam int TW = (NUMW > DENW + QW) ? NUMW : DENW + QW;

  logic [TW-1:0]   rem [QW+1];
  logic [DENW-1:0] dv  [QW+1];
  logic [QW-1:0]   qv  [QW+1];
  logic            ov  [QW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= TW'(num);
      dv[0]  <= den;
      qv[0]  <= '0;
      ov[0]  <= (TW'(num) >> QW) >= TW'(den);
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_bit
    localparam int K = QW - 1 - s;
    logic [TW-1:0] trial;

    assign trial = TW'(dv[s]) << K;

    always_ff @(posedge clk) begin
      if (en) begin
        dv[s+1] <= dv[s];
        ov[s+1] <= ov[s];
        if (rem[s] >= trial) begin
          rem[s+1] <= rem[s] - trial;
          qv[s+1]  <= qv[s] | (QW'(1) << K);
        end else begin
          rem[s+1] <= rem[s];
          qv[s+1]  <= qv[s];
        end
      end
    end
  end

  assign quo = qv[QW];
  assign ovf = ov[QW];

endmodule

`default_nettype wire

// ----- sv/tetra_circumcentre.sv -----
// ----------------------------------------------------------------------------
// tetra_circumcentre: circumsphere centre of a tetrahedron
// Vertices come in on the vtx channel as signed fixed-point coordinates; the
// centre leaves on the centre channel in the same format with a status code.
//
// Usage:
//   vtx channel    : p0_x .. p3_z, transfer when vtx_valid && !vtx_stall.
//   centre channel : centre_x/y/z and status, transfer when centre_valid &&
//                    !centre_stall. Status: ok, degenerate (zero determinant,
//                    centre is vertex 0) or saturated (a component clamped).
//   Pipeline       : edge vectors, two three-stage multiplier banks, sums,
//                    then the one-bit-per-stage quotient pipeline and the
//                    output register.
//   Throughput     : one tetrahedron per cycle while no result is held
//                    in the output register; results in input order.
//   Stall          : a stalled result holds in the output register; while it
//                    holds, the whole pipeline freezes and vtx_stall is high,
//                    so nothing is lost or repeated. A free output register
//                    lets the pipeline advance even while results are pending.
//   Reset          : clears all valid bits; data registers are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module tetra_circumcentre import tcc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          vtx_valid,
  output logic                          vtx_stall,
  input  logic signed [COORD_WIDTH-1:0] p0_x,
  input  logic signed [COORD_WIDTH-1:0] p0_y,
  input  logic signed [COORD_WIDTH-1:0] p0_z,
  input  logic signed [COORD_WIDTH-1:0] p1_x,
  input  logic signed [COORD_WIDTH-1:0] p1_y,
  input  logic signed [COORD_WIDTH-1:0] p1_z,
  input  logic signed [COORD_WIDTH-1:0] p2_x,
  input  logic signed [COORD_WIDTH-1:0] p2_y,
  input  logic signed [COORD_WIDTH-1:0] p2_z,
  input  logic signed [COORD_WIDTH-1:0] p3_x,
  input  logic signed [COORD_WIDTH-1:0] p3_y,
  input  logic signed [COORD_WIDTH-1:0] p3_z,
  output logic                          centre_valid,
  input  logic                          centre_stall,
  output logic signed [COORD_WIDTH-1:0] centre_x,
  output logic signed [COORD_WIDTH-1:0] centre_y,
  output logic signed [COORD_WIDTH-1:0] centre_z,
  output logic [STATUS_W-1:0]           status
);

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * DW;
  localparam int CRW  = PW + 1;
  localparam int SQW  = PW + 2;
  localparam int DETW = DW + CRW + 2;
  localparam int NW   = SQW + CRW + 2;
  localparam int NUMW = NW + 1;
  localparam int DENW = DETW + 1;
  localparam int QW   = CW + 2;
  localparam int EW   = CW + 4;
  localparam int NSTG = QW + 12;

  localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

  logic en;
  logic vld [NSTG];

  logic signed [CW-1:0]   pin [4][3];
  logic signed [DW-1:0]   d   [3][3];
  logic signed [CW-1:0]   p0r [3];
  logic [9*DW-1:0]        dpk;
  logic [9*DW-1:0]        ddpk;
  logic signed [DW-1:0]   dd  [3][3];
  logic [3*CW-1:0]        p0pk;
  logic [3*CW-1:0]        p0dpk;
  logic signed [CW-1:0]   p0d [3];

  logic signed [PW-1:0]   pa  [3][3];
  logic signed [PW-1:0]   pb  [3][3];
  logic signed [PW-1:0]   sqp [3][3];
  logic signed [CRW-1:0]  cr  [3][3];
  logic signed [SQW-1:0]  sq  [3];

  logic signed [DW+CRW-1:0]  detp [3];
  logic signed [SQW+CRW-1:0] np   [3][3];
  logic signed [DETW-1:0]    det;
  logic signed [NW-1:0]      nn   [3];

  logic            zero;
  logic [DETW-1:0] adet;
  logic [NW-1:0]   an  [3];
  logic [2:0]      sgn;
  logic [NUMW-1:0] num [3];
  logic [DENW-1:0] den;

  logic [QW-1:0]   quo [3];
  logic [2:0]      ovf;
  logic [3:0]      flg;
  logic [3:0]      flgd;

  logic signed [EW-1:0] qe  [3];
  logic signed [EW-1:0] sum [3];
  logic signed [CW-1:0] res [3];
  logic [STATUS_W-1:0]  stat;

  assign en        = !centre_valid || !centre_stall;
  assign vtx_stall = !en;

  assign pin[0][0] = p0_x;
  assign pin[0][1] = p0_y;
  assign pin[0][2] = p0_z;
  assign pin[1][0] = p1_x;
  assign pin[1][1] = p1_y;
  assign pin[1][2] = p1_z;
  assign pin[2][0] = p2_x;
  assign pin[2][1] = p2_y;
  assign pin[2][2] = p2_z;
  assign pin[3][0] = p3_x;
  assign pin[3][1] = p3_y;
  assign pin[3][2] = p3_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSTG; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= vtx_valid;
      for (int i = 1; i < NSTG; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  // edge vectors from vertex 0
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p0r[k] <= pin[0][k];
        for (int v = 0; v < 3; v++) begin
          d[v][k] <= DW'(pin[v+1][k]) - DW'(pin[0][k]);
        end
      end
    end
  end

  for (genvar v = 0; v < 3; v++) begin : g_pack
    assign p0pk[v*CW +: CW] = p0r[v];
    assign p0d[v]           = $signed(p0dpk[v*CW +: CW]);
    for (genvar k = 0; k < 3; k++) begin : g_pk
      assign dpk[(v*3+k)*DW +: DW] = d[v][k];
      assign dd[v][k]              = $signed(ddpk[(v*3+k)*DW +: DW]);
    end
  end

  tcc_dly #(.W(9*DW), .N(4)) u_ddly (
    .clk (clk),
    .en  (en),
    .d   (dpk),
    .q   (ddpk)
  );

  tcc_dly #(.W(3*CW), .N(QW+11)) u_pdly (
    .clk (clk),
    .en  (en),
    .d   (p0pk),
    .q   (p0dpk)
  );

  // cross products: m = 0 gives d2 x d3, m = 1 gives d3 x d1, m = 2 gives d1 x d2
  for (genvar m = 0; m < 3; m++) begin : g_cross
    for (genvar k = 0; k < 3; k++) begin : g_cc
      tcc_mul #(.AW(DW), .BW(DW)) u_pa (
        .clk (clk),
        .en  (en),
        .a   (d[(m+1)%3][(k+1)%3]),
        .b   (d[(m+2)%3][(k+2)%3]),
        .p   (pa[m][k])
      );
      tcc_mul #(.AW(DW), .BW(DW)) u_pb (
        .clk (clk),
        .en  (en),
        .a   (d[(m+1)%3][(k+2)%3]),
        .b   (d[(m+2)%3][(k+1)%3]),
        .p   (pb[m][k])
      );
      tcc_mul #(.AW(DW), .BW(DW)) u_sq (
        .clk (clk),
        .en  (en),
        .a   (d[m][k]),
        .b   (d[m][k]),
        .p   (sqp[m][k])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int m = 0; m < 3; m++) begin
        sq[m] <= SQW'(sqp[m][0]) + SQW'(sqp[m][1]) + SQW'(sqp[m][2]);
        for (int k = 0; k < 3; k++) begin
          cr[m][k] <= CRW'(pa[m][k]) - CRW'(pb[m][k]);
        end
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_second
    tcc_mul #(.AW(DW), .BW(CRW)) u_det (
      .clk (clk),
      .en  (en),
      .a   (dd[0][k]),
      .b   (cr[0][k]),
      .p   (detp[k])
    );
    for (genvar v = 0; v < 3; v++) begin : g_nv
      tcc_mul #(.AW(SQW), .BW(CRW)) u_num (
        .clk (clk),
        .en  (en),
        .a   (sq[v]),
        .b   (cr[v][k]),
        .p   (np[k][v])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det <= DETW'(detp[0]) + DETW'(detp[1]) + DETW'(detp[2]);
      for (int k = 0; k < 3; k++) begin
        nn[k] <= NW'(np[k][0]) + NW'(np[k][1]) + NW'(np[k][2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero <= (det == '0);
      adet <= det[DETW-1] ? DETW'(-det) : DETW'(det);
      for (int k = 0; k < 3; k++) begin
        an[k]  <= nn[k][NW-1] ? NW'(-nn[k]) : NW'(nn[k]);
        sgn[k] <= nn[k][NW-1] ^ det[DETW-1];
      end
    end
  end

  // round half away from zero: (|N| + |D|) / (2 |D|)
  always_ff @(posedge clk) begin
    if (en) begin
      den <= {adet, 1'b0};
      for (int k = 0; k < 3; k++) begin
        num[k] <= NUMW'(an[k]) + NUMW'(adet);
      end
    end
  end

  assign flg = {zero, sgn};

  tcc_dly #(.W(4), .N(QW+2)) u_fdly (
    .clk (clk),
    .en  (en),
    .d   (flg),
    .q   (flgd)
  );

  for (genvar k = 0; k < 3; k++) begin : g_div
    tcc_div #(.NUMW(NUMW), .DENW(DENW), .QW(QW)) u_div (
      .clk (clk),
      .en  (en),
      .num (num[k]),
      .den (den),
      .quo (quo[k]),
      .ovf (ovf[k])
    );
  end

  always_comb begin
    stat = STATUS_OK;
    for (int k = 0; k < 3; k++) begin
      qe[k]  = $signed(EW'(quo[k]));
      sum[k] = EW'(p0d[k]) + (flgd[k] ? -qe[k] : qe[k]);
      if (flgd[3]) begin
        res[k] = p0d[k];
      end else if (ovf[k]) begin
        res[k] = flgd[k] ? MINV : MAXV;
        stat   = STATUS_SAT;
      end else if (sum[k] > EW'(MAXV)) begin
        res[k] = MAXV;
        stat   = STATUS_SAT;
      end else if (sum[k] < EW'(MINV)) begin
        res[k] = MINV;
        stat   = STATUS_SAT;
      end else begin
        res[k] = sum[k][CW-1:0];
      end
    end
    if (flgd[3]) begin
      stat = STATUS_DEGEN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_valid <= 1'b0;
    end else if (en) begin
      centre_valid <= vld[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      centre_x <= res[0];
      centre_y <= res[1];
      centre_z <= res[2];
      status   <= stat;
    end
  end

`ifndef ASSERT_OFF
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    centre_valid |-> (status == STATUS_OK || status == STATUS_DEGEN ||
                      status == STATUS_SAT))
    else $error("centre status outside its codes");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    centre_valid && status == STATUS_SAT |->
      (centre_x == MAXV || centre_x == MINV || centre_y == MAXV ||
       centre_y == MINV || centre_z == MAXV || centre_z == MINV))
    else $error("saturated status without a clamped component");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld[NSTG-1]) && $stable(vld[0]))
    else $error("pipeline moved while the output was held");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !centre_valid && !vld[0])
    else $error("valid bits not cleared by reset");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: tetra_circumcentre checker
// Streams tetrahedra through the block with random gaps and output stalls,
// predicts each centre and status with wide exact integer arithmetic, save for
// directed rows given by hand, and compares every result transfer in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench import tcc_pkg::*;;

  localparam int CW = 32;
  localparam int N_RANDOM = 1300;
  localparam int LATENCY = CW + 15;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [255:0] wide_t;

  typedef struct {
    coord_t p [12];
  } tetra_t;

  typedef struct packed {
    coord_t cx;
    coord_t cy;
    coord_t cz;
    logic [STATUS_W-1:0] st;
  } centre_t;

  typedef struct {
    tetra_t t;
    logic known;
    centre_t c;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic vtx_valid = 1'b0;
  logic vtx_stall;
  coord_t vin [12];
  logic centre_valid;
  logic centre_stall = 1'b0;
  coord_t centre_x, centre_y, centre_z;
  logic [STATUS_W-1:0] status;

  centre_t pending_centres [$];
  int errors = 0;
  int n_results = 0;
  int n_degen = 0;
  int n_sat = 0;
  logic stim_done = 1'b0;
  logic hold_off = 1'b0;

  initial begin
    for (int i = 0; i < 12; i++) vin[i] = '0;
  end

  tetra_circumcentre #(.COORD_WIDTH(CW)) dut (
    .clk(clk), .rst(rst),
    .vtx_valid(vtx_valid), .vtx_stall(vtx_stall),
    .p0_x(vin[0]), .p0_y(vin[1]), .p0_z(vin[2]),
    .p1_x(vin[3]), .p1_y(vin[4]), .p1_z(vin[5]),
    .p2_x(vin[6]), .p2_y(vin[7]), .p2_z(vin[8]),
    .p3_x(vin[9]), .p3_y(vin[10]), .p3_z(vin[11]),
    .centre_valid(centre_valid), .centre_stall(centre_stall),
    .centre_x(centre_x), .centre_y(centre_y), .centre_z(centre_z),
    .status(status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic centre_t circumcentre(tetra_t t);
    wide_t p [4][3];
    wide_t d [3][3];
    wide_t c23 [3], c31 [3], c12 [3], sq [3];
    wide_t det, adet, num, q, r, hi, lo;
    centre_t c;
    for (int v = 0; v < 4; v++)
      for (int k = 0; k < 3; k++) p[v][k] = t.p[v*3+k];
    for (int v = 0; v < 3; v++)
      for (int k = 0; k < 3; k++) d[v][k] = p[v+1][k] - p[0][k];
    for (int k = 0; k < 3; k++) begin
      c23[k] = d[1][(k+1)%3]*d[2][(k+2)%3] - d[1][(k+2)%3]*d[2][(k+1)%3];
      c31[k] = d[2][(k+1)%3]*d[0][(k+2)%3] - d[2][(k+2)%3]*d[0][(k+1)%3];
      c12[k] = d[0][(k+1)%3]*d[1][(k+2)%3] - d[0][(k+2)%3]*d[1][(k+1)%3];
    end
    for (int v = 0; v < 3; v++)
      sq[v] = d[v][0]*d[v][0] + d[v][1]*d[v][1] + d[v][2]*d[v][2];
    det = d[0][0]*c23[0] + d[0][1]*c23[1] + d[0][2]*c23[2];
    c.st = STATUS_OK;
    if (det == 0) begin
      c.cx = t.p[0];
      c.cy = t.p[1];
      c.cz = t.p[2];
      c.st = STATUS_DEGEN;
      return c;
    end
    adet = (det < 0) ? -det : det;
    hi = coord_t'({1'b0, {(CW-1){1'b1}}});
    lo = coord_t'({1'b1, {(CW-1){1'b0}}});
    for (int k = 0; k < 3; k++) begin
      num = sq[0]*c23[k] + sq[1]*c31[k] + sq[2]*c12[k];
      q = wide_t'(((num < 0) ? -num : num) + adet) / (adet * 2);
      if ((num < 0) != (det < 0)) q = -q;
      r = p[0][k] + q;
      if (r > hi) begin
        r = hi;
        c.st = STATUS_SAT;
      end else if (r < lo) begin
        r = lo;
        c.st = STATUS_SAT;
      end
      if (k == 0) c.cx = r[CW-1:0];
      else if (k == 1) c.cy = r[CW-1:0];
      else c.cz = r[CW-1:0];
    end
    return c;
  endfunction

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 2047)) - 1024;
      2: return coord_t'($urandom_range(0, 1 << 22)) - (1 << 21);
      default: return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
    endcase
  endfunction

  function automatic tetra_t rand_tetra();
    tetra_t t;
    int mode;
    int shape;
    mode = $urandom_range(0, 9);
    mode = (mode < 2) ? 0 : (mode < 5) ? 1 : (mode < 9) ? 2 : 3;
    for (int i = 0; i < 12; i++) t.p[i] = rand_coord(mode);
    shape = $urandom_range(0, 15);
    if (shape == 0) begin
      // coplanar: put every vertex on one z plane
      for (int v = 1; v < 4; v++) t.p[v*3+2] = t.p[2];
    end else if (shape == 1) begin
      // coincident pair
      for (int k = 0; k < 3; k++) t.p[9+k] = t.p[3+k];
    end else if (shape == 2) begin
      // nearly flat: large centre, often clamped
      for (int v = 1; v < 4; v++) t.p[v*3+2] = t.p[2] + $urandom_range(0, 1);
    end
    return t;
  endfunction

  task automatic send_tetra(tetra_t t, centre_t want);
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      vtx_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vtx_valid <= 1'b1;
    for (int i = 0; i < 12; i++) vin[i] <= t.p[i];
    pending_centres.push_back(want);
    @(posedge clk);
    while (vtx_stall) @(posedge clk);
  endtask

  function automatic tetra_t make_tetra(coord_t a, coord_t b, coord_t c, coord_t d);
    tetra_t t;
    for (int i = 0; i < 12; i++) t.p[i] = '0;
    t.p[0] = a;
    t.p[1] = a;
    t.p[2] = a;
    t.p[3] = a + b;
    t.p[7] = a + c;
    t.p[11] = a + d;
    return t;
  endfunction

  stim_row_t dir_rows [$];
  coord_t cmax, cmin;

  initial begin
    tetra_t t;
    tetra_t rt;
    stim_row_t row;
    cmax = {1'b0, {(CW-1){1'b1}}};
    cmin = {1'b1, {(CW-1){1'b0}}};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all zero: degenerate, centre is vertex 0
    for (int i = 0; i < 12; i++) t.p[i] = '0;
    row = '{t: t, known: 1'b1, c: '{0, 0, 0, STATUS_DEGEN}};
    dir_rows.push_back(row);
    // all vertices at the positive extreme
    for (int i = 0; i < 12; i++) t.p[i] = cmax;
    row = '{t: t, known: 1'b1, c: '{cmax, cmax, cmax, STATUS_DEGEN}};
    dir_rows.push_back(row);
    for (int i = 0; i < 12; i++) t.p[i] = cmin;
    row = '{t: t, known: 1'b1, c: '{cmin, cmin, cmin, STATUS_DEGEN}};
    dir_rows.push_back(row);
    // unit corner tetrahedron, centre at half unit
    t = make_tetra(0, 32'sh10000, 32'sh10000, 32'sh10000);
    row = '{t: t, known: 1'b1, c: '{32'sh8000, 32'sh8000, 32'sh8000, STATUS_OK}};
    dir_rows.push_back(row);
    // odd legs: rounding ties away from zero; then vertex 0 at each extreme
    row.known = 1'b0;
    row.t = make_tetra(0, 1, 1, 1);
    dir_rows.push_back(row);
    row.t = make_tetra(0, -1, -1, -1);
    dir_rows.push_back(row);
    row.t = make_tetra(0, 3, -5, 7);
    dir_rows.push_back(row);
    row.t = make_tetra(cmax, 32'sh10000, 32'sh10000, 32'sh10000);
    dir_rows.push_back(row);
    row.t = make_tetra(cmin, -32'sh10000, -32'sh10000, -32'sh10000);
    dir_rows.push_back(row);
    // spanning the whole range
    for (int i = 0; i < 12; i++) t.p[i] = '0;
    t.p[0] = cmin; t.p[3] = cmax; t.p[7] = cmax; t.p[11] = cmin + 1;
    row.t = t;
    dir_rows.push_back(row);
    for (int i = 0; i < 12; i++) t.p[i] = (i % 2) ? cmax : cmin;
    row.t = t;
    dir_rows.push_back(row);
    for (int i = 0; i < 12; i++) t.p[i] = ((i * 7) % 5 < 2) ? cmax : cmin;
    row.t = t;
    dir_rows.push_back(row);
    for (int i = 0; i < 12; i++) t.p[i] = 32'sh55555555 ^ (i[0] ? 32'hffffffff : 0);
    t.p[4] = 32'sh1234; t.p[8] = -32'sh1234;
    row.t = t;
    dir_rows.push_back(row);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].known) send_tetra(dir_rows[i].t, dir_rows[i].c);
      else send_tetra(dir_rows[i].t, circumcentre(dir_rows[i].t));
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      rt = rand_tetra();
      send_tetra(rt, circumcentre(rt));
    end
    vtx_valid <= 1'b0;
    stim_done <= 1'b1;
  end

  // output side: random stall, with one long hold-off
  initial begin
    @(negedge rst);
    repeat (200) @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    int wait_cycles;
    wait_cycles = 0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        centre_stall <= 1'b1;
      end else if (centre_valid && !centre_stall) begin
        wait_cycles = $urandom_range(0, 3);
        centre_stall <= (wait_cycles != 0);
      end else if (wait_cycles > 0) begin
        wait_cycles--;
        centre_stall <= (wait_cycles != 0);
      end else begin
        centre_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    centre_t want;
    if (!rst && centre_valid && !centre_stall) begin
      if (pending_centres.size() == 0) begin
        $error("centre transfer with nothing pending");
        errors++;
      end else begin
        want = pending_centres.pop_front();
        n_results++;
        if (want.st == STATUS_DEGEN) n_degen++;
        if (want.st == STATUS_SAT) n_sat++;
        if (centre_x !== want.cx) begin
          $error("centre_x expected %0d got %0d", want.cx, centre_x);
          errors++;
        end
        if (centre_y !== want.cy) begin
          $error("centre_y expected %0d got %0d", want.cy, centre_y);
          errors++;
        end
        if (centre_z !== want.cz) begin
          $error("centre_z expected %0d got %0d", want.cz, centre_z);
          errors++;
        end
        if (status !== want.st) begin
          $error("status expected %0d got %0d", want.st, status);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (pending_centres.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("%0d centres checked: %0d degenerate, %0d saturated.", n_results, n_degen, n_sat);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #400000;
    $display("timeout: %0d centres still pending", pending_centres.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
